// ===== rtl/core/string_to_unsigned_parser_defines.svh =====
// Assertion shorthands for the parser checker. All are clocked on i_clk.
`ifndef STRING_TO_UNSIGNED_PARSER_DEFINES_SVH
`define STRING_TO_UNSIGNED_PARSER_DEFINES_SVH

// same-cycle implication, off while in reset
`define STR2U_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define STR2U_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// what must hold right after a reset edge
`define STR2U_ASSERT_RST(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/str2u_pkg.sv =====
`default_nettype none

package str2u_pkg;

    localparam int WORD_BITS   = 64;
    localparam int OFFSET_BITS = 16;
    localparam int CHAR_BITS   = 8;
    localparam int BASE_BITS   = 6;

    localparam logic [BASE_BITS-1:0] BASE_RESET = BASE_BITS'(10);

    typedef struct packed {
        logic [CHAR_BITS-1:0] character;
        logic                 first_of_string;
    } t_in_beat;

    typedef struct packed {
        logic [WORD_BITS-1:0]   value;
        logic                   overflowed;
        logic                   digits_found;
        logic [OFFSET_BITS-1:0] end_offset;
    } t_out_beat;

endpackage

`default_nettype wire

// ===== rtl/core/string_to_unsigned_parser.sv =====
// Streaming unsigned-number parser (strtoul semantics), one text byte per beat.
// Input channel: i_in_valid / o_in_ready carry {character, first_of_string}.
//   A beat with first_of_string set restarts the parse at offset 0; bytes seen
//   before any such beat, or after a result, are dropped silently.
// Output channel: o_out_valid / i_out_ready carry {value, overflowed,
//   digits_found, end_offset}; one beat per string, at the first non-digit.
// Config: i_cfg_we writes the radix (0 = auto) from i_cfg_data; it is picked
//   up by the next first_of_string beat. Reset value is 10.
// A terminating byte reaches its result via the input and output registers.
//   Throughput is one byte per cycle while the output is not stalled, set by
//   the combinational multiply-add on the 64-bit accumulator fed by each digit.
// An input register and an output register separate the two channels, so a
//   byte is taken even while a finished result sits waiting. When the output
//   is stalled with a result pending, the parser holds its current byte and
//   o_in_ready drops once the input register is full.
// Reset (synchronous, active low) clears the parse state, both registers'
//   valid flags and restores the radix to 10.
`default_nettype none

module string_to_unsigned_parser (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [str2u_pkg::BASE_BITS-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire str2u_pkg::t_in_beat             i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output str2u_pkg::t_out_beat                 o_out_data
);
    import str2u_pkg::*;

    logic     beat_valid;
    t_in_beat beat;
    logic     take;

    str2u_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_take       (take),
        .o_beat_valid (beat_valid),
        .o_beat       (beat)
    );

    str2u_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_beat_valid (beat_valid),
        .i_beat       (beat),
        .o_take       (take),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

`default_nettype wire

// ===== rtl/core/str2u_in_stage.sv =====
`default_nettype none

module str2u_in_stage (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire str2u_pkg::t_in_beat i_in_data,
    input  wire logic                i_take,
    output logic                     o_beat_valid,
    output str2u_pkg::t_in_beat      o_beat
);
    import str2u_pkg::*;

    logic     r_valid;
    t_in_beat r_beat;

    // a slot frees up in the same cycle the parser consumes it
    assign o_in_ready   = !r_valid || i_take;
    assign o_beat_valid = r_valid;
    assign o_beat       = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_beat <= i_in_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/str2u_mac.sv =====
`default_nettype none

module str2u_mac (
    input  wire logic [str2u_pkg::WORD_BITS-1:0] i_acc,
    input  wire logic [str2u_pkg::BASE_BITS-1:0] i_base,
    input  wire logic [str2u_pkg::BASE_BITS-1:0] i_digit,
    output logic [str2u_pkg::WORD_BITS-1:0]      o_sum,
    output logic                                 o_carry
);
    import str2u_pkg::*;

    localparam int FULL_BITS = WORD_BITS + BASE_BITS;

    logic [FULL_BITS-1:0] full;

    // digit < base, so acc*base+digit leaves the word exactly when strtoul's
    // limit/remainder test trips
    assign full    = FULL_BITS'(i_acc) * FULL_BITS'(i_base) + FULL_BITS'(i_digit);
    assign o_sum   = full[WORD_BITS-1:0];
    assign o_carry = |full[FULL_BITS-1:WORD_BITS];

endmodule

`default_nettype wire

// ===== rtl/core/str2u_parse.sv =====
`default_nettype none

module str2u_parse (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [str2u_pkg::BASE_BITS-1:0]     i_cfg_data,
    input  wire logic                                i_beat_valid,
    input  wire str2u_pkg::t_in_beat                 i_beat,
    output logic                                     o_take,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output str2u_pkg::t_out_beat                     o_out_data
);
    import str2u_pkg::*;

    localparam int DIGIT_BITS = 7;
    localparam logic [DIGIT_BITS-1:0]  DIGIT_NONE = DIGIT_BITS'(99);
    localparam logic [OFFSET_BITS-1:0] POS_MAX    = '1;

    localparam logic [CHAR_BITS-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_BITS-1:0] CH_LZ    = 8'h7A;
    localparam logic [CHAR_BITS-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_BITS-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_BITS-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_BITS-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;

    localparam logic [BASE_BITS-1:0] BASE_AUTO = BASE_BITS'(0);
    localparam logic [BASE_BITS-1:0] BASE_OCT  = BASE_BITS'(8);
    localparam logic [BASE_BITS-1:0] BASE_DEC  = BASE_BITS'(10);
    localparam logic [BASE_BITS-1:0] BASE_HEX  = BASE_BITS'(16);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SPACE,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS
    } t_phase;

    function automatic logic [DIGIT_BITS-1:0] f_digit_value(input logic [CHAR_BITS-1:0] ch);
        logic [DIGIT_BITS-1:0] v;
        v = DIGIT_NONE;
        if (ch inside {[CH_0:CH_9]}) begin
            v = DIGIT_BITS'(ch - CH_0);
        end else if (ch inside {[CH_LA:CH_LZ]}) begin
            v = DIGIT_BITS'(ch - CH_LA + 8'd10);
        end else if (ch inside {[CH_UA:CH_UZ]}) begin
            v = DIGIT_BITS'(ch - CH_UA + 8'd10);
        end
        return v;
    endfunction

    t_phase                 r_phase;
    logic [WORD_BITS-1:0]   r_acc;
    logic                   r_neg;
    logic                   r_ovf;
    logic                   r_any;
    logic [BASE_BITS-1:0]   r_base;
    logic [OFFSET_BITS-1:0] r_pos;
    logic [BASE_BITS-1:0]   r_number_base;
    logic                   r_out_valid;
    t_out_beat              r_out_data;

    // state as seen after an optional restart
    t_phase                 w_phase;
    logic [WORD_BITS-1:0]   w_acc;
    logic                   w_neg;
    logic                   w_ovf;
    logic                   w_any;
    logic [BASE_BITS-1:0]   w_base;
    logic [OFFSET_BITS-1:0] w_pos;

    t_phase                 phase_a;
    logic                   any_a;
    logic                   after_sign;
    logic                   do_digit;
    logic [CHAR_BITS-1:0]   c;
    logic [DIGIT_BITS-1:0]  dv;
    logic                   ends;
    logic                   adds;
    logic [WORD_BITS-1:0]   mac_sum;
    logic                   mac_carry;

    t_phase                 n_phase;
    logic [WORD_BITS-1:0]   n_acc;
    logic                   n_neg;
    logic                   n_ovf;
    logic                   n_any;
    logic [BASE_BITS-1:0]   n_base;
    logic [OFFSET_BITS-1:0] n_pos;
    t_out_beat              n_out;

    assign c      = i_beat.character;
    assign o_take = i_beat_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        if (i_beat.first_of_string) begin
            w_phase = PH_SPACE;
            w_acc   = '0;
            w_neg   = 1'b0;
            w_ovf   = 1'b0;
            w_any   = 1'b0;
            w_base  = r_number_base;
            w_pos   = '0;
        end else begin
            w_phase = r_phase;
            w_acc   = r_acc;
            w_neg   = r_neg;
            w_ovf   = r_ovf;
            w_any   = r_any;
            w_base  = r_base;
            w_pos   = r_pos;
        end
    end

    // phase walk: whitespace, sign, held zero for a possible 0x prefix
    always_comb begin
        phase_a    = w_phase;
        n_neg      = w_neg;
        n_base     = w_base;
        any_a      = w_any;
        after_sign = 1'b0;
        do_digit   = 1'b0;
        case (w_phase)
            PH_SPACE: begin
                if (c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR}) begin
                    phase_a = PH_SPACE;
                end else if (c == CH_MINUS) begin
                    n_neg   = 1'b1;
                    phase_a = PH_SIGNED;
                end else if (c == CH_PLUS) begin
                    phase_a = PH_SIGNED;
                end else begin
                    after_sign = 1'b1;
                end
            end
            PH_SIGNED: begin
                after_sign = 1'b1;
            end
            PH_ZERO: begin
                if (c == CH_LX || c == CH_UX) begin
                    n_base  = BASE_HEX;
                    phase_a = PH_DIGITS;
                end else begin
                    if (w_base == BASE_AUTO) begin
                        n_base = BASE_OCT;
                    end
                    // the held zero counts as a digit; accumulator is still zero
                    any_a    = 1'b1;
                    phase_a  = PH_DIGITS;
                    do_digit = 1'b1;
                end
            end
            PH_DIGITS: begin
                do_digit = 1'b1;
            end
            default: begin
                phase_a = PH_IDLE;
            end
        endcase
        if (after_sign) begin
            if ((w_base == BASE_AUTO || w_base == BASE_HEX) && c == CH_0) begin
                phase_a = PH_ZERO;
            end else begin
                if (w_base == BASE_AUTO) begin
                    n_base = BASE_DEC;
                end
                phase_a  = PH_DIGITS;
                do_digit = 1'b1;
            end
        end
    end

    assign dv   = f_digit_value(c);
    assign ends = do_digit && (dv >= DIGIT_BITS'(n_base));
    assign adds = do_digit && !ends;

    str2u_mac u_mac (
        .i_acc   (w_acc),
        .i_base  (n_base),
        .i_digit (dv[BASE_BITS-1:0]),
        .o_sum   (mac_sum),
        .o_carry (mac_carry)
    );

    always_comb begin
        n_phase = ends ? PH_IDLE : phase_a;
        n_any   = any_a || adds;
        n_acc   = w_acc;
        n_ovf   = w_ovf;
        if (adds) begin
            if (w_ovf || mac_carry) begin
                n_ovf = 1'b1;
            end else begin
                n_acc = mac_sum;
            end
        end
        if (w_phase != PH_IDLE && w_pos != POS_MAX) begin
            n_pos = w_pos + 1'b1;
        end else begin
            n_pos = w_pos;
        end

        if (w_ovf) begin
            n_out.value = '1;
        end else if (w_neg) begin
            n_out.value = '0 - w_acc;
        end else begin
            n_out.value = w_acc;
        end
        n_out.overflowed   = w_ovf;
        n_out.digits_found = any_a;
        n_out.end_offset   = any_a ? w_pos : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_acc         <= '0;
            r_neg         <= 1'b0;
            r_ovf         <= 1'b0;
            r_any         <= 1'b0;
            r_base        <= BASE_RESET;
            r_pos         <= '0;
            r_number_base <= BASE_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_number_base <= i_cfg_data;
            end
            if (o_take) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_neg   <= n_neg;
                r_ovf   <= n_ovf;
                r_any   <= n_any;
                r_base  <= n_base;
                r_pos   <= n_pos;
            end
            if (o_take && ends) begin
                r_out_valid <= 1'b1;
                r_out_data  <= n_out;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ===== rtl/core/str2u_checker.sv =====
`default_nettype none
`include "string_to_unsigned_parser_defines.svh"

module str2u_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_ready,
    input wire str2u_pkg::t_out_beat            o_out_data
);
    import str2u_pkg::*;

    `STR2U_ASSERT_RST(a_idle_after_reset, !o_out_valid, "result valid right after reset")

    `STR2U_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "stalled result beat changed")

    `STR2U_ASSERT_IMP(a_no_digits_zero, o_out_valid && !o_out_data.digits_found, o_out_data.end_offset == '0 && o_out_data.value == '0 && !o_out_data.overflowed, "empty parse must report zero")

    `STR2U_ASSERT_IMP(a_ovf_all_ones, o_out_valid && o_out_data.overflowed, (&o_out_data.value) && o_out_data.digits_found, "overflow must force all ones")

    `STR2U_ASSERT_IMP(a_digits_offset, o_out_valid && o_out_data.digits_found, o_out_data.end_offset != '0, "digits found but end offset is zero")

endmodule

bind string_to_unsigned_parser str2u_checker u_str2u_checker (.*);

`default_nettype wire
